>>> hw/rtl/chacha20_stream_cipher_core_assert.svh
// assertion macros shared by the cipher rtl
// depends on nothing; define NO_ASSERTIONS to drop all checks
`ifndef CHACHA20_STREAM_CIPHER_CORE_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CHK_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`else
`define CHK_IMPL(lbl, clk, rst, ante, cons)
`define CHK_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/chacha_pkg.sv
// types, constants and the quarter round for the cipher core
// depends on nothing
package chacha_pkg;
   localparam int ROUND_COUNT = 20;
   localparam int DROUNDS = ROUND_COUNT / 2;
   localparam int RCNT_W = $clog2(DROUNDS + 1);
   localparam logic [2:0] CSR_NONCE = 3'd4;

   typedef logic [31:0] word_type;
   typedef word_type [15:0] state_type;

   typedef struct packed {
      logic [63:0] data_bytes;
      logic [3:0]  byte_count;
      logic        first_item;
      logic        last_item;
   } req_type;

   typedef struct packed {
      logic [63:0] out_bytes;
      logic [3:0]  out_count;
      logic        out_last;
      logic        counter_overflow;
   } rsp_type;

   // front to back queue entry
   typedef struct packed {
      req_type req;
      logic    need_block;
   } job_type;

   typedef struct packed {
      logic [255:0] key;
      logic [63:0]  nonce;
   } cfg_type;

   localparam word_type SIGMA0 = 32'h61707865;
   localparam word_type SIGMA1 = 32'h3320646e;
   localparam word_type SIGMA2 = 32'h79622d32;
   localparam word_type SIGMA3 = 32'h6b206574;

   function automatic word_type rotl(input word_type v, input int n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   function automatic logic [127:0] qround(input word_type a, input word_type b,
                                           input word_type c, input word_type d);
      word_type a1, b1, c1, d1;
      a1 = a + b;   d1 = rotl(d ^ a1, 16);
      c1 = c + d1;  b1 = rotl(b ^ c1, 12);
      a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
      c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
      qround = {a1, b1, c1, d1};
   endfunction

   function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (cnt > 4'(i)) m[8*i +: 8] = 8'hff;
      end
      byte_mask = m;
   endfunction
endpackage

>>> hw/rtl/chacha20_stream_cipher_core.sv
// chacha20 stream cipher core, 64-bit counter and 64-bit nonce
// depends on chacha_pkg, chacha_front, chacha_back
//
// req beats carry up to eight data bytes; each gives one rsp beat with the
// bytes xored by the next keystream word (invalid bytes zero).
// csr writes set key parts 0..3 (index 0..3) and the nonce (index 4);
// write only while the core is idle.
// a beat at word position zero or with first_item set starts a new block:
// the start loads the round state in ST_IDLE, ST_COL and ST_DIAG alternate
// for ROUND_COUNT rounds (one column or one diagonal round each), and in
// ST_FIN such a beat is taken from the queue and its result registered.
// other beats are taken in ST_IDLE with the stored keystream words; the rate
// is set by the single shared round engine, which runs one block at a time.
// a two-entry queue sits between the front and the round engine; the
// result register holds while it is valid and rsp_stall is high, and
// req_stall rises when the queue fills.
// reset clears counter, position, overflow flag and all valid state;
// key and nonce reset to zero.
module chacha20_stream_cipher_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  chacha_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output chacha_pkg::rsp_type  rsp_data,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [63:0]          csr_wdata
);
   import chacha_pkg::*;

   cfg_type cfg_ff;
   logic    q_valid, q_stall;
   job_type q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         if (csr_index < CSR_NONCE) cfg_ff.key[64*csr_index[1:0] +: 64] <= csr_wdata;
         else if (csr_index == CSR_NONCE) cfg_ff.nonce <= csr_wdata;
      end
   end

   chacha_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .q_valid(q_valid), .q_stall(q_stall), .q_data(q_data)
   );

   chacha_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .q_valid(q_valid), .q_stall(q_stall), .q_data(q_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );
endmodule

>>> hw/rtl/chacha_front.sv
// front part: accepts beats, tracks word position, flags block starts
// depends on chacha_pkg and chacha20_stream_cipher_core_assert.svh
module chacha_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  chacha_pkg::req_type  req_data,
   output logic                 q_valid,
   input  logic                 q_stall,
   output chacha_pkg::job_type  q_data
);
   import chacha_pkg::*;

   logic [2:0] pos_ff, pos_in;
   logic [1:0] cnt_ff;
   job_type    buf_ff [2];
   logic       wr_ff, rd_ff;
   logic       push, pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && !q_stall;
   assign q_data = buf_ff[rd_ff];
   assign pos_in = req_data.first_item ? 3'd1 : pos_ff + 3'd1;

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ff].req <= req_data;
         buf_ff[wr_ff].need_block <= req_data.first_item || (pos_ff == 3'd0);
      end
      if (reset) begin
         pos_ff <= '0;
         cnt_ff <= '0;
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
      end else begin
         if (push) begin
            pos_ff <= pos_in;
            wr_ff <= !wr_ff;
         end
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

`include "chacha20_stream_cipher_core_assert.svh"
   `CHK_IMPL(a_no_overfill, clock, reset, cnt_ff == 2'd2, !push)
   `CHK_IMPL(a_no_underrun, clock, reset, cnt_ff == 2'd0, !pop)
   `CHK_NEXT(a_first_pos, clock, reset, push && req_data.first_item, pos_ff == 3'd1)
endmodule

>>> hw/rtl/chacha_back.sv
// back part: runs double rounds for new blocks and xors data into result beats
// depends on chacha_pkg and chacha20_stream_cipher_core_assert.svh
module chacha_back (
   input  logic                 clock,
   input  logic                 reset,
   input  chacha_pkg::cfg_type  cfg,
   input  logic                 q_valid,
   output logic                 q_stall,
   input  chacha_pkg::job_type  q_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output chacha_pkg::rsp_type  rsp_data
);
   import chacha_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_COL, ST_DIAG, ST_FIN} st_type;

   st_type            st_ff;
   state_type         init_ff, work_ff;
   logic [RCNT_W-1:0] rnd_ff;
   logic [63:0]       ks_ff [8];
   logic [2:0]        pos_ff;
   logic [63:0]       ctr_ff;
   logic              ovf_ff;
   logic              out_v_ff;
   rsp_type           out_ff;
   logic              out_free, take, start;
   logic [63:0]       ctr_use, ks_word;
   state_type         init_in, col_in, diag_in;
   logic [127:0]      qr [4];

   assign out_free = !out_v_ff || !rsp_stall;
   assign ctr_use = q_data.req.first_item ? 64'd0 : ctr_ff;
   assign start = (st_ff == ST_IDLE) && q_valid && q_data.need_block;
   assign take = q_valid && out_free &&
                 ((st_ff == ST_IDLE && !q_data.need_block) || st_ff == ST_FIN);
   assign q_stall = !take;
   assign rsp_valid = out_v_ff;
   assign rsp_data = out_ff;

   always_comb begin
      init_in[0] = SIGMA0; init_in[1] = SIGMA1;
      init_in[2] = SIGMA2; init_in[3] = SIGMA3;
      for (int k = 0; k < 8; k++) init_in[4+k] = cfg.key[32*k +: 32];
      init_in[12] = ctr_use[31:0];
      init_in[13] = ctr_use[63:32];
      init_in[14] = cfg.nonce[31:0];
      init_in[15] = cfg.nonce[63:32];
   end

   always_comb begin
      col_in = work_ff;
      diag_in = work_ff;
      for (int i = 0; i < 4; i++) begin
         if (st_ff == ST_COL)
            qr[i] = qround(work_ff[i], work_ff[4+i], work_ff[8+i], work_ff[12+i]);
         else
            qr[i] = qround(work_ff[i], work_ff[4+((i+1)%4)],
                           work_ff[8+((i+2)%4)], work_ff[12+((i+3)%4)]);
      end
      for (int i = 0; i < 4; i++) begin
         col_in[i] = qr[i][127:96];        col_in[4+i] = qr[i][95:64];
         col_in[8+i] = qr[i][63:32];       col_in[12+i] = qr[i][31:0];
         diag_in[i] = qr[i][127:96];       diag_in[4+((i+1)%4)] = qr[i][95:64];
         diag_in[8+((i+2)%4)] = qr[i][63:32]; diag_in[12+((i+3)%4)] = qr[i][31:0];
      end
   end

   assign ks_word = (st_ff == ST_FIN) ?
      {work_ff[1] + init_ff[1], work_ff[0] + init_ff[0]} : ks_ff[pos_ff];

   always_ff @(posedge clock) begin
      if (start) begin
         init_ff <= init_in;
         work_ff <= init_in;
      end else if (st_ff == ST_COL) begin
         work_ff <= col_in;
      end else if (st_ff == ST_DIAG) begin
         work_ff <= diag_in;
      end
      if (st_ff == ST_FIN && take) begin
         for (int k = 0; k < 8; k++)
            ks_ff[k] <= {work_ff[2*k+1] + init_ff[2*k+1], work_ff[2*k] + init_ff[2*k]};
      end
      if (take) begin
         out_ff.out_bytes <= (q_data.req.data_bytes ^ ks_word) &
                             byte_mask(q_data.req.byte_count);
         out_ff.out_count <= q_data.req.byte_count;
         out_ff.out_last <= q_data.req.last_item;
         out_ff.counter_overflow <= (st_ff == ST_FIN) ?
            ((q_data.req.first_item ? 1'b0 : ovf_ff) || (ctr_use == '1)) : ovf_ff;
      end
      if (reset) begin
         st_ff <= ST_IDLE;
         rnd_ff <= '0;
         pos_ff <= '0;
         ctr_ff <= '0;
         ovf_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (take) out_v_ff <= 1'b1;
         else if (!rsp_stall) out_v_ff <= 1'b0;
         unique case (st_ff)
            ST_IDLE: begin
               if (start) begin
                  st_ff <= ST_COL;
                  rnd_ff <= '0;
               end else if (take) begin
                  pos_ff <= pos_ff + 3'd1;
               end
            end
            ST_COL: st_ff <= ST_DIAG;
            ST_DIAG: begin
               rnd_ff <= rnd_ff + RCNT_W'(1);
               st_ff <= (rnd_ff == RCNT_W'(DROUNDS - 1)) ? ST_FIN : ST_COL;
            end
            ST_FIN: begin
               if (take) begin
                  st_ff <= ST_IDLE;
                  pos_ff <= 3'd1;
                  ctr_ff <= ctr_use + 64'd1;
                  ovf_ff <= (q_data.req.first_item ? 1'b0 : ovf_ff) || (ctr_use == '1);
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

`include "chacha20_stream_cipher_core_assert.svh"
   `CHK_IMPL(a_take_state, clock, reset, take, st_ff == ST_IDLE || st_ff == ST_FIN)
   `CHK_NEXT(a_take_shows, clock, reset, take, out_v_ff)
   `CHK_NEXT(a_col_diag, clock, reset, st_ff == ST_COL, st_ff == ST_DIAG)
endmodule
